@@ src/pfs16_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs16_pkg
// Shared types and constants for the packet framer with additive checksum.
// ----------------------------------------------------------------------------
package pfs16_pkg;

	// Input word kinds, carried on s_tuser.
	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// Work queued from the front end to the back end.
	typedef enum logic {
		CMD_HEADER  = 1'b0,
		CMD_PAYLOAD = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;     // message type for a header, the byte for a payload
		logic [15:0] seq;      // sequence number for a header
		logic [15:0] len;      // payload length for a header
		logic        close;    // the checksum follows this command
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	// Byte positions within the emitted frame.
	typedef logic [3:0] pos_t;
	localparam pos_t POS_VERSION  = 4'd0;
	localparam pos_t POS_TYPE     = 4'd1;
	localparam pos_t POS_SEQ_HI   = 4'd2;
	localparam pos_t POS_SEQ_LO   = 4'd3;
	localparam pos_t POS_TOKEN_0  = 4'd4;
	localparam pos_t POS_TOKEN_1  = 4'd5;
	localparam pos_t POS_TOKEN_2  = 4'd6;
	localparam pos_t POS_TOKEN_3  = 4'd7;
	localparam pos_t POS_LEN_B3   = 4'd8;
	localparam pos_t POS_LEN_B2   = 4'd9;
	localparam pos_t POS_LEN_HI   = 4'd10;
	localparam pos_t POS_LEN_LO   = 4'd11;
	localparam pos_t POS_HDR_SUMH = 4'd12;
	localparam pos_t POS_HDR_SUML = 4'd13;
	localparam pos_t POS_PAY_DATA = 4'd0;
	localparam pos_t POS_PAY_SUMH = 4'd1;
	localparam pos_t POS_PAY_SUML = 4'd2;

	localparam logic [7:0] SENDER_TOKEN_BYTE = 8'hFF;
	localparam logic [7:0] VERSION_RESET     = 8'd1;

endpackage

@@ src/packet_framer_sum16_unit.sv @@
// ----------------------------------------------------------------------------
// packet_framer_sum16_unit
// Frames outgoing packets as a byte stream with an additive 16-bit checksum.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ channel. A start word (s_tuser low) opens a
// packet and yields a 12-byte header: version, type, sequence number, four
// token bytes of 0xFF and a 32-bit big-endian length. Payload words
// (s_tuser high) pass their byte through. After the last payload byte, or at
// once for a zero length, the 16-bit sum of all packet bytes follows, high
// byte first, with m_tlast on the low byte. A start word while a packet is
// open, and a payload word with none open, produce nothing.
// The front end classifies each word combinationally and queues a command;
// the back end expands one command into bytes, one byte per cycle unless
// m_tready stalls, into the output register. Each byte passes through the
// command queue and then the output register. Payload bytes sustain one per
// cycle when nothing stalls; a header yields 12 bytes (14 with an empty
// payload), a closing payload word 3; s_tready drops only on a full queue.
// A stalled m_tready holds the output byte and backs up through the queue.
// Reset empties the queue, closes any packet, clears the sequence number and
// sets the version register to 1.
// ----------------------------------------------------------------------------
module packet_framer_sum16_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: protocol version.
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // message_type[7:0], payload_length[23:8], data_byte[31:24]
	input  logic        s_tuser,   // op[0]
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast
);

	import pfs16_pkg::*;

	logic [7:0]       version_q;
	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_valid;
	cmd_t             push_cmd;
	logic [CMD_W-1:0] head_bits;

	// Protocol version register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
		end else if (cfg_we) begin
			version_q <= cfg_wdata;
		end
	end

	pfs16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_type  (s_tdata[7:0]),
		.in_len   (s_tdata[23:8]),
		.in_byte  (s_tdata[31:24]),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	pfs16_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (head_bits)
	);

	pfs16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.version   (version_q),
		.q_valid   (q_valid),
		.q_cmd     (cmd_t'(head_bits)),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

@@ src/pfs16_fifo.sv @@
// ----------------------------------------------------------------------------
// pfs16_fifo
// Small register-based queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pfs16_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage writes.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/pfs16_front.sv @@
// ----------------------------------------------------------------------------
// pfs16_front
// Accepts input words, tracks the open packet and queues framing commands.
// ----------------------------------------------------------------------------
module pfs16_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_op,
	input  logic [7:0]        in_type,
	input  logic [15:0]       in_len,
	input  logic [7:0]        in_byte,
	input  logic              q_full,
	output logic              q_push,
	output pfs16_pkg::cmd_t   q_cmd
);

	import pfs16_pkg::*;

	logic        open_q;
	logic [15:0] left_q;
	logic [15:0] seq_q;
	logic        accept;
	logic        is_start;
	logic        is_payload;
	logic        last_byte;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign is_start   = (in_op == OP_START) && !open_q;
	assign is_payload = (in_op == OP_PAYLOAD) && open_q;
	assign last_byte  = (left_q == 16'd1);

	// Build the command; ignored words push nothing.
	always_comb begin
		q_push     = accept && (is_start || is_payload);
		q_cmd.seq  = seq_q;
		q_cmd.len  = in_len;
		if (is_start) begin
			q_cmd.kind  = CMD_HEADER;
			q_cmd.data  = in_type;
			q_cmd.close = (in_len == 16'd0);
		end else begin
			q_cmd.kind  = CMD_PAYLOAD;
			q_cmd.data  = in_byte;
			q_cmd.close = last_byte;
		end
	end

	// Packet state and sequence number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= '0;
			seq_q  <= '0;
		end else if (accept) begin
			if (is_start) begin
				seq_q  <= seq_q + 16'd1;
				open_q <= (in_len != 16'd0);
				left_q <= in_len;
			end else if (is_payload) begin
				left_q <= left_q - 16'd1;
				if (last_byte) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ src/pfs16_back.sv @@
// ----------------------------------------------------------------------------
// pfs16_back
// Expands queued commands into frame bytes, keeps the checksum and drives
// the output register.
// ----------------------------------------------------------------------------
module pfs16_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        version,
	input  logic              q_valid,
	input  pfs16_pkg::cmd_t   q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	import pfs16_pkg::*;

	pos_t        pos_q;
	logic [15:0] sum_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        fire;
	logic [7:0]  cur_byte;
	logic        summed;
	logic        end_cmd;
	logic        is_eop;
	pos_t        last_pos;

	assign fire      = q_valid && (!valid_q || out_ready);
	assign q_pop     = fire && end_cmd;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	// Select the byte at the current position of the command.
	always_comb begin
		cur_byte = 8'd0;
		summed   = 1'b1;
		if (q_cmd.kind == CMD_HEADER) begin
			last_pos = q_cmd.close ? POS_HDR_SUML : POS_LEN_LO;
			case (pos_q)
				POS_VERSION:  cur_byte = version;
				POS_TYPE:     cur_byte = q_cmd.data;
				POS_SEQ_HI:   cur_byte = q_cmd.seq[15:8];
				POS_SEQ_LO:   cur_byte = q_cmd.seq[7:0];
				POS_TOKEN_0,
				POS_TOKEN_1,
				POS_TOKEN_2,
				POS_TOKEN_3:  cur_byte = SENDER_TOKEN_BYTE;
				POS_LEN_B3,
				POS_LEN_B2:   cur_byte = 8'd0;
				POS_LEN_HI:   cur_byte = q_cmd.len[15:8];
				POS_LEN_LO:   cur_byte = q_cmd.len[7:0];
				POS_HDR_SUMH: begin
					cur_byte = sum_q[15:8];
					summed   = 1'b0;
				end
				default: begin
					cur_byte = sum_q[7:0];
					summed   = 1'b0;
				end
			endcase
		end else begin
			last_pos = q_cmd.close ? POS_PAY_SUML : POS_PAY_DATA;
			case (pos_q)
				POS_PAY_DATA: cur_byte = q_cmd.data;
				POS_PAY_SUMH: begin
					cur_byte = sum_q[15:8];
					summed   = 1'b0;
				end
				default: begin
					cur_byte = sum_q[7:0];
					summed   = 1'b0;
				end
			endcase
		end
		end_cmd = (pos_q == last_pos);
		is_eop  = end_cmd && q_cmd.close;
	end

	// Position counter and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (fire) begin
			pos_q <= end_cmd ? '0 : pos_q + 4'd1;
			if (summed) begin
				if (q_cmd.kind == CMD_HEADER && pos_q == POS_VERSION) begin
					sum_q <= {8'd0, cur_byte};
				end else begin
					sum_q <= sum_q + {8'd0, cur_byte};
				end
			end
		end
	end

	// Output register; it refills in the cycle its word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= cur_byte;
			last_q <= is_eop;
		end
	end

endmodule
